[hw/rtl/ptb_pkg.sv]
`default_nettype none

package ptb_pkg;

   localparam int COUNT_W = 15;
   localparam int PRESET_W = 16;
   localparam int PRESCALE_W = 4;
   localparam int BANK_COUNT = 4;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 15'h7FFF;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CLEAR = 5'b00010,
      ST_SWEEP = 5'b00100,
      ST_EVAL  = 5'b01000,
      ST_RESP  = 5'b10000
   } state_type;

   typedef struct packed {
      logic                 done;
      logic [COUNT_W-1:0]   count;
   } entry_type;

endpackage

`default_nettype wire

[hw/rtl/plc_timer_bank.sv]
// Evaluate transaction: entry read, then written in ST_EVAL, result staged in ST_RESP.
// Tick transaction: sweeps the first N banks, where N (1 to 4) is the number of
// timebases that advance; one timer counter is read and written back per cycle in the sweep.
// One transaction at a time: a new one is taken only after the last result is staged.
// After reset, a clearing pass zeroes all 4 * TIMERS_PER_BANK timer entries;
// no transaction is accepted until it ends. Prescalers and handshake state clear at once.
`default_nettype none

module plc_timer_bank #(
   parameter int TIMERS_PER_BANK = 16,
   parameter int PRESCALE_RATIO = 10
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_op,
   input  wire logic [1:0]  req_bank,
   input  wire logic [3:0]  req_timer_index,
   input  wire logic        req_start_req,
   input  wire logic [15:0] req_preset,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_done_res,
   output logic [14:0]      rsp_elapsed
);

   localparam int DEPTH = ptb_pkg::BANK_COUNT * TIMERS_PER_BANK;
   localparam int AW = $clog2(DEPTH);
   localparam int CW = AW + 1;
   localparam int PW = ptb_pkg::PRESCALE_W;
   localparam int NW = ptb_pkg::COUNT_W;

   ptb_pkg::state_type state_ff, state_in;
   logic [CW-1:0]           sweep_ff, sweep_in;
   logic [CW-1:0]           sweep_end_ff, sweep_end_in;
   logic [CW-1:0]           sweep_next;
   logic                    wb_valid_ff, wb_valid_in;
   logic [AW-1:0]           wb_addr_ff, wb_addr_in;
   logic [PW-1:0]           ms_ff, ms_in;
   logic [PW-1:0]           ten_ff, ten_in;
   logic [PW-1:0]           hun_ff, hun_in;
   logic [AW-1:0]           eval_addr_ff, eval_addr_in;
   logic                    eval_start_ff, eval_start_in;
   logic [15:0]             eval_preset_ff, eval_preset_in;
   logic                    res_done_ff, res_done_in;
   logic [NW-1:0]           res_elapsed_ff, res_elapsed_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_done_ff, rsp_done_in;
   logic [NW-1:0]           rsp_elapsed_ff, rsp_elapsed_in;

   ptb_pkg::entry_type      mem [DEPTH];
   ptb_pkg::entry_type      rd_data_ff;
   ptb_pkg::entry_type      wr_data;
   logic [AW-1:0]           rd_addr;
   logic [AW-1:0]           wr_addr;
   logic                    wr_en;

   logic [PW-1:0]           ms_inc, ten_inc, hun_inc;
   logic                    adv1, adv2, adv3;
   logic [2:0]              bank_num;
   logic                    idx_ok;
   logic [AW-1:0]           slot;
   logic [NW-1:0]           sat_count;

   assign req_ready = (state_ff == ptb_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_done_res = rsp_done_ff;
   assign rsp_elapsed = rsp_elapsed_ff;

   assign ms_inc = ms_ff + PW'(1);
   assign adv1 = (ms_inc >= PW'(PRESCALE_RATIO));
   assign ten_inc = adv1 ? ten_ff + PW'(1) : ten_ff;
   assign adv2 = (ten_inc >= PW'(PRESCALE_RATIO));
   assign hun_inc = adv2 ? hun_ff + PW'(1) : hun_ff;
   assign adv3 = (hun_inc >= PW'(PRESCALE_RATIO));
   assign bank_num = 3'd1 + 3'(adv1) + 3'(adv2) + 3'(adv3);

   assign idx_ok = (32'(req_timer_index) < TIMERS_PER_BANK);
   assign slot = AW'(req_bank) * AW'(TIMERS_PER_BANK) + AW'(req_timer_index);
   assign sweep_next = sweep_ff + CW'(1);
   assign sat_count = (rd_data_ff.count != ptb_pkg::COUNT_MAX) ?
                      rd_data_ff.count + NW'(1) : rd_data_ff.count;

   always_comb begin
      state_in = state_ff;
      sweep_in = sweep_ff;
      sweep_end_in = sweep_end_ff;
      wb_valid_in = 1'b0;
      wb_addr_in = wb_addr_ff;
      ms_in = ms_ff;
      ten_in = ten_ff;
      hun_in = hun_ff;
      eval_addr_in = eval_addr_ff;
      eval_start_in = eval_start_ff;
      eval_preset_in = eval_preset_ff;
      res_done_in = res_done_ff;
      res_elapsed_in = res_elapsed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_done_in = rsp_done_ff;
      rsp_elapsed_in = rsp_elapsed_ff;
      rd_addr = sweep_ff[AW-1:0];
      wr_en = wb_valid_ff;
      wr_addr = wb_addr_ff;
      wr_data.done = rd_data_ff.done;
      wr_data.count = sat_count;

      unique case (state_ff)
         ptb_pkg::ST_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = sweep_ff[AW-1:0];
            wr_data = '0;
            sweep_in = sweep_next;
            if (sweep_next == sweep_end_ff) begin
               state_in = ptb_pkg::ST_IDLE;
            end
         end
         ptb_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_op == ptb_pkg::OP_TICK) begin
                  ms_in = adv1 ? '0 : ms_inc;
                  ten_in = adv2 ? '0 : ten_inc;
                  hun_in = adv3 ? '0 : hun_inc;
                  sweep_in = '0;
                  sweep_end_in = CW'(bank_num) * CW'(TIMERS_PER_BANK);
                  state_in = ptb_pkg::ST_SWEEP;
               end else if (idx_ok) begin
                  rd_addr = slot;
                  eval_addr_in = slot;
                  eval_start_in = req_start_req;
                  eval_preset_in = req_preset;
                  state_in = ptb_pkg::ST_EVAL;
               end else begin
                  res_done_in = 1'b0;
                  res_elapsed_in = '0;
                  state_in = ptb_pkg::ST_RESP;
               end
            end
         end
         ptb_pkg::ST_SWEEP: begin
            rd_addr = sweep_ff[AW-1:0];
            wb_valid_in = 1'b1;
            wb_addr_in = sweep_ff[AW-1:0];
            sweep_in = sweep_next;
            if (sweep_next == sweep_end_ff) begin
               res_done_in = 1'b0;
               res_elapsed_in = '0;
               state_in = ptb_pkg::ST_RESP;
            end
         end
         ptb_pkg::ST_EVAL: begin
            wr_en = 1'b1;
            wr_addr = eval_addr_ff;
            if (eval_start_ff) begin
               wr_data.count = rd_data_ff.count;
               wr_data.done = ({1'b0, rd_data_ff.count} >= eval_preset_ff);
            end else begin
               wr_data = '0;
            end
            res_done_in = wr_data.done;
            res_elapsed_in = wr_data.count;
            state_in = ptb_pkg::ST_RESP;
         end
         ptb_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_done_in = res_done_ff;
               rsp_elapsed_in = res_elapsed_ff;
               state_in = ptb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ptb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptb_pkg::ST_CLEAR;
         sweep_ff <= '0;
         sweep_end_ff <= CW'(DEPTH);
         wb_valid_ff <= 1'b0;
         ms_ff <= '0;
         ten_ff <= '0;
         hun_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         sweep_end_ff <= sweep_end_in;
         wb_valid_ff <= wb_valid_in;
         ms_ff <= ms_in;
         ten_ff <= ten_in;
         hun_ff <= hun_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wb_addr_ff <= wb_addr_in;
      eval_addr_ff <= eval_addr_in;
      eval_start_ff <= eval_start_in;
      eval_preset_ff <= eval_preset_in;
      res_done_ff <= res_done_in;
      res_elapsed_ff <= res_elapsed_in;
      rsp_done_ff <= rsp_done_in;
      rsp_elapsed_ff <= rsp_elapsed_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

`ifndef SYNTH
   a_bad_index_zero: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_op == ptb_pkg::OP_EVAL && !idx_ok)
      |=> (state_ff == ptb_pkg::ST_RESP && !res_done_ff && res_elapsed_ff == '0))
      else $error("out-of-range evaluate did not yield a zero result");

   a_wb_in_range: assert property (@(posedge clock) disable iff (reset)
      wb_valid_ff |-> (CW'(wb_addr_ff) < sweep_end_ff))
      else $error("sweep write-back beyond the advanced banks");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ptb_pkg::ST_RESP))
      else $error("result raised outside the response state");
`endif

endmodule

`default_nettype wire
